[src/pjc_pkg.sv]
// ----------------------------------------------------------------------------
// pjc_pkg
// Shared types, constants and the odd-prime table for the pseudosquare
// Jacobi check core.
// ----------------------------------------------------------------------------
package pjc_pkg;

  // fixed field widths of the channels
  localparam int N_VALUE_W     = 64;
  localparam int LIMIT_W       = 10;

  // prime table geometry
  localparam int PRIME_ROM_LEN = 73;
  localparam int PRIME_W       = 9;
  localparam int ROM_IDX_W     = 7;

  // radix-4 digits needed to reduce a 9-bit residue
  localparam int JAC_DIGITS    = 5;

  // request to the shared remainder unit
  typedef struct packed {
    logic start;
    logic short_op;   // 1: reduce the 9-bit operand, 0: reduce the candidate
  } mod_req_t;

  // odd primes 3..373
  function automatic logic [PRIME_W-1:0] prime_rom(input logic [ROM_IDX_W-1:0] idx);
    logic [PRIME_W-1:0] q;
    case (idx)
      7'd0:  q = 9'd3;    7'd1:  q = 9'd5;    7'd2:  q = 9'd7;    7'd3:  q = 9'd11;
      7'd4:  q = 9'd13;   7'd5:  q = 9'd17;   7'd6:  q = 9'd19;   7'd7:  q = 9'd23;
      7'd8:  q = 9'd29;   7'd9:  q = 9'd31;   7'd10: q = 9'd37;   7'd11: q = 9'd41;
      7'd12: q = 9'd43;   7'd13: q = 9'd47;   7'd14: q = 9'd53;   7'd15: q = 9'd59;
      7'd16: q = 9'd61;   7'd17: q = 9'd67;   7'd18: q = 9'd71;   7'd19: q = 9'd73;
      7'd20: q = 9'd79;   7'd21: q = 9'd83;   7'd22: q = 9'd89;   7'd23: q = 9'd97;
      7'd24: q = 9'd101;  7'd25: q = 9'd103;  7'd26: q = 9'd107;  7'd27: q = 9'd109;
      7'd28: q = 9'd113;  7'd29: q = 9'd127;  7'd30: q = 9'd131;  7'd31: q = 9'd137;
      7'd32: q = 9'd139;  7'd33: q = 9'd149;  7'd34: q = 9'd151;  7'd35: q = 9'd157;
      7'd36: q = 9'd163;  7'd37: q = 9'd167;  7'd38: q = 9'd173;  7'd39: q = 9'd179;
      7'd40: q = 9'd181;  7'd41: q = 9'd191;  7'd42: q = 9'd193;  7'd43: q = 9'd197;
      7'd44: q = 9'd199;  7'd45: q = 9'd211;  7'd46: q = 9'd223;  7'd47: q = 9'd227;
      7'd48: q = 9'd229;  7'd49: q = 9'd233;  7'd50: q = 9'd239;  7'd51: q = 9'd241;
      7'd52: q = 9'd251;  7'd53: q = 9'd257;  7'd54: q = 9'd263;  7'd55: q = 9'd269;
      7'd56: q = 9'd271;  7'd57: q = 9'd277;  7'd58: q = 9'd281;  7'd59: q = 9'd283;
      7'd60: q = 9'd293;  7'd61: q = 9'd307;  7'd62: q = 9'd311;  7'd63: q = 9'd313;
      7'd64: q = 9'd317;  7'd65: q = 9'd331;  7'd66: q = 9'd337;  7'd67: q = 9'd347;
      7'd68: q = 9'd349;  7'd69: q = 9'd353;  7'd70: q = 9'd359;  7'd71: q = 9'd367;
      7'd72: q = 9'd373;
      default: q = 9'd373;
    endcase
    return q;
  endfunction

endpackage

[src/pjc_mod_unit.sv]
// ----------------------------------------------------------------------------
// pjc_mod_unit
// Shared remainder unit: restoring reduction by a 9-bit odd divisor, two
// dividend bits per cycle, most significant first.
// ----------------------------------------------------------------------------
module pjc_mod_unit #(
  parameter int N_WIDTH = 64
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pjc_pkg::mod_req_t            req,
  input  logic [N_WIDTH-1:0]           dividend,
  input  logic [pjc_pkg::PRIME_W-1:0]  short_value,
  input  logic [pjc_pkg::PRIME_W-1:0]  divisor,
  output logic                         done,
  output logic [pjc_pkg::PRIME_W-1:0]  rem
);
  import pjc_pkg::*;

  localparam int LongW   = 2 * ((N_WIDTH + 1) / 2);
  localparam int ShW     = (LongW > 2 * JAC_DIGITS) ? LongW : 2 * JAC_DIGITS;
  localparam int LongDig = ShW / 2;
  localparam int CntW    = $clog2(LongDig + 1);

  logic [ShW-1:0]     sh_r, sh_nxt;
  logic [PRIME_W-1:0] rem_r, rem_nxt;
  logic [PRIME_W-1:0] div_r, div_nxt;
  logic [CntW-1:0]    cnt_r, cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;

  // one restoring step: shift in a bit, subtract the divisor if it fits
  function automatic logic [PRIME_W-1:0] rstep(input logic [PRIME_W-1:0] r,
                                               input logic b,
                                               input logic [PRIME_W-1:0] d);
    logic [PRIME_W:0] t;
    t = {r, b};
    if (t >= {1'b0, d}) begin
      t = t - {1'b0, d};
    end
    return t[PRIME_W-1:0];
  endfunction

  // next-state logic
  always_comb begin
    sh_nxt   = sh_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      div_nxt  = divisor;
      rem_nxt  = '0;
      busy_nxt = 1'b1;
      if (req.short_op) begin
        sh_nxt  = ShW'(short_value) << (ShW - 2 * JAC_DIGITS);
        cnt_nxt = CntW'(JAC_DIGITS);
      end else begin
        sh_nxt  = ShW'(dividend);
        cnt_nxt = CntW'(LongDig);
      end
    end else if (busy_r) begin
      rem_nxt = rstep(rstep(rem_r, sh_r[ShW-1], div_r), sh_r[ShW-2], div_r);
      sh_nxt  = sh_r << 2;
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CntW'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

[src/pseudosquare_jacobi_check_core.sv]
// ----------------------------------------------------------------------------
// pseudosquare_jacobi_check_core
// Pseudosquare candidate test: n = 1 mod 8 and Jacobi (n | q) = 1 for every
// tabulated odd prime q up to the given limit.
// ----------------------------------------------------------------------------
// One transaction is worked on at a time. A candidate that is not 1 mod 8
// goes from S_IDLE straight to S_DONE. Otherwise each checked prime costs one
// pass of the shared remainder unit over the candidate plus the Jacobi loop on
// the 9-bit residue: a halving step for each factor of two, and a short pass
// of the same remainder unit for every reciprocity swap. The finished result
// sits in an output register, so the next candidate is taken while the previous
// result waits for out_ready.
module pseudosquare_jacobi_check_core #(
  parameter int NUM_PRIMES = 73,
  parameter int N_WIDTH    = 64
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [pjc_pkg::N_VALUE_W-1:0]  in_n_value,
  input  logic [pjc_pkg::LIMIT_W-1:0]    in_prime_limit,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_is_pseudo
);
  import pjc_pkg::*;

  localparam int Count = (NUM_PRIMES > PRIME_ROM_LEN) ? PRIME_ROM_LEN :
                         ((NUM_PRIMES < 1) ? 1 : NUM_PRIMES);
  localparam int IdxW  = (Count > 1) ? $clog2(Count) : 1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHK,
    S_MODN,
    S_JAC,
    S_JMOD,
    S_DONE
  } state_t;

  state_t             state_r;
  logic [N_WIDTH-1:0] n_r;
  logic [LIMIT_W-1:0] limit_r;
  logic [IdxW-1:0]    idx_r;
  logic [PRIME_W-1:0] x_r;
  logic [PRIME_W-1:0] m_r;
  logic               neg_r;
  logic               pass_r;
  logic               out_valid_r;
  logic               out_is_pseudo_r;

  logic [PRIME_W-1:0] q;
  logic               q_over;
  logic               jac_swap;
  logic               swap_flip;
  logic               half_flip;
  mod_req_t           mod_req;
  logic               mod_done;
  logic [PRIME_W-1:0] mod_rem;

  // current prime and whether it lies above the limit
  assign q      = prime_rom(ROM_IDX_W'(idx_r));
  assign q_over = {1'b0, q} > limit_r;

  // jacobi step decisions
  assign jac_swap  = (state_r == S_JAC) && (x_r != '0) && x_r[0];
  assign swap_flip = (m_r[1:0] == 2'b11) && (x_r[1:0] == 2'b11);
  assign half_flip = (m_r[2:0] == 3'd3) || (m_r[2:0] == 3'd5);

  // remainder unit requests
  always_comb begin
    mod_req.start    = ((state_r == S_CHK) && !q_over) || jac_swap;
    mod_req.short_op = (state_r == S_JAC);
  end

  pjc_mod_unit #(
    .N_WIDTH (N_WIDTH)
  ) u_mod (
    .clk         (clk),
    .rst_n       (rst_n),
    .req         (mod_req),
    .dividend    (n_r),
    .short_value (m_r),
    .divisor     ((state_r == S_CHK) ? q : x_r),
    .done        (mod_done),
    .rem         (mod_rem)
  );

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= S_IDLE;
      out_valid_r     <= 1'b0;
      out_is_pseudo_r <= 1'b0;
      idx_r           <= '0;
      neg_r           <= 1'b0;
      pass_r          <= 1'b0;
    end else begin
      // output register drains; in S_DONE the reload below decides instead
      if (out_valid_r && out_ready && (state_r != S_DONE)) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            n_r     <= in_n_value[N_WIDTH-1:0];
            limit_r <= in_prime_limit;
            idx_r   <= '0;
            if (in_n_value[2:0] != 3'd1) begin
              pass_r  <= 1'b0;
              state_r <= S_DONE;
            end else begin
              state_r <= S_CHK;
            end
          end
        end
        S_CHK: begin
          if (q_over) begin
            pass_r  <= 1'b1;
            state_r <= S_DONE;
          end else begin
            m_r     <= q;
            state_r <= S_MODN;
          end
        end
        S_MODN: begin
          if (mod_done) begin
            x_r     <= mod_rem;
            neg_r   <= 1'b0;
            state_r <= S_JAC;
          end
        end
        S_JAC: begin
          if (x_r == '0) begin
            if ((m_r == PRIME_W'(1)) && !neg_r) begin
              if (idx_r == IdxW'(Count - 1)) begin
                pass_r  <= 1'b1;
                state_r <= S_DONE;
              end else begin
                idx_r   <= idx_r + 1'b1;
                state_r <= S_CHK;
              end
            end else begin
              pass_r  <= 1'b0;
              state_r <= S_DONE;
            end
          end else if (!x_r[0]) begin
            x_r   <= x_r >> 1;
            neg_r <= neg_r ^ half_flip;
          end else begin
            // swap: new modulus is the odd x, old modulus gets reduced by it
            m_r     <= x_r;
            neg_r   <= neg_r ^ swap_flip;
            state_r <= S_JMOD;
          end
        end
        S_JMOD: begin
          if (mod_done) begin
            x_r     <= mod_rem;
            state_r <= S_JAC;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r     <= 1'b1;
            out_is_pseudo_r <= pass_r;
            state_r         <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  assign in_ready      = (state_r == S_IDLE);
  assign out_valid     = out_valid_r;
  assign out_is_pseudo = out_is_pseudo_r;

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for pseudosquare_jacobi_check_core. Candidates are sent
// through the input handshake, an independent predictor works out the
// pseudosquare verdict for each accepted transaction, and every result that
// leaves the block is compared with the oldest pending verdict. Directed
// corner cases run first, then a hold-off test, then a random mix dominated
// by odd squares and 1 mod 8 values; random sender gaps and receiver stalls throughout.
// ----------------------------------------------------------------------------
module testbench;

  localparam int  CORE_NUM_PRIMES = 73;
  localparam int  CORE_N_WIDTH    = 64;
  localparam int  TABLE_LEN       = 73;
  localparam int  FULL_LIMIT      = 373;
  localparam int  RANDOM_ITEMS    = 240;
  localparam int  HOLD_CYCLES     = 300;
  localparam int  IDLE_LIMIT      = 60000;
  localparam int  TAIL_CYCLES     = 200;

  typedef enum int {READY_ALWAYS, READY_RANDOM, READY_PERIODIC} ready_mode_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_valid;
  logic                            in_ready;
  logic [pjc_pkg::N_VALUE_W-1:0]   in_n_value;
  logic [pjc_pkg::LIMIT_W-1:0]     in_prime_limit;
  logic                            out_valid;
  logic                            out_ready;
  logic                            out_is_pseudo;

  // pending verdicts, oldest first
  bit          expected_pseudo[$];
  int unsigned odd_primes[TABLE_LEN];
  int          fail_count;
  int          burst_left;
  int          candidates_sent;
  int          full_table_items;
  int          passing_seen;
  int          idle_cycles;
  bit          hold_off_req;

  pseudosquare_jacobi_check_core #(
    .NUM_PRIMES(CORE_NUM_PRIMES),
    .N_WIDTH   (CORE_N_WIDTH)
  ) u_top (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_n_value    (in_n_value),
    .in_prime_limit(in_prime_limit),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_is_pseudo (out_is_pseudo)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // odd primes 3.. by trial division, independent of the block's rom
  function automatic void fill_odd_primes();
    int unsigned cand;
    int          found;
    bit          is_prime;
    found = 0;
    cand  = 3;
    while (found < TABLE_LEN) begin
      is_prime = 1'b1;
      for (int unsigned d = 3; d * d <= cand; d += 2)
        if (cand % d == 0) is_prime = 1'b0;
      if (is_prime) begin
        odd_primes[found] = cand;
        found++;
      end
      cand += 2;
    end
  endfunction

  // jacobi symbol (x | m) by binary reciprocity, m odd, x already below m
  function automatic int jacobi_of_residue(int unsigned x, int unsigned m);
    int          sgn;
    int unsigned t;
    sgn = 1;
    if (x == 0) return 0;
    while (x != 0) begin
      while ((x & 1) == 0) begin
        x = x >> 1;
        if ((m & 7) == 3 || (m & 7) == 5) sgn = -sgn;
      end
      t = x;
      x = m;
      m = t;
      if ((x & 3) == 3 && (m & 3) == 3) sgn = -sgn;
      x = x % m;
    end
    return (m == 1) ? sgn : 0;
  endfunction

  // verdict for one candidate
  function automatic bit predict_pseudo(logic [63:0] n_raw, logic [9:0] lim);
    logic [63:0] n;
    logic [63:0] rem;
    int          count;
    n     = n_raw & ({64{1'b1}} >> (64 - CORE_N_WIDTH));
    count = (CORE_NUM_PRIMES > TABLE_LEN) ? TABLE_LEN : CORE_NUM_PRIMES;
    if (count < 1) count = 1;
    if (n[2:0] != 3'd1) return 1'b0;
    for (int i = 0; i < count; i++) begin
      if (odd_primes[i] > lim) break;
      rem = n % 64'(odd_primes[i]);
      if (jacobi_of_residue(int'(rem), odd_primes[i]) != 1) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [63:0] odd_square(logic [31:0] k);
    logic [63:0] k64;
    k64 = {32'd0, k | 32'd1};
    return k64 * k64;
  endfunction

  // offer one candidate, honoring the sender's burst pattern
  task automatic send_candidate(input logic [63:0] n, input logic [9:0] lim);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      burst_left = $urandom_range(1, 16);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid       <= 1'b1;
    in_n_value     <= n;
    in_prime_limit <= lim;
    do @(posedge clk); while (!in_ready);
    expected_pseudo.push_back(predict_pseudo(n, lim));
    candidates_sent++;
    if (lim >= FULL_LIMIT) full_table_items++;
  endtask

  // stop offering and wait for every pending verdict
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_pseudo.size() != 0);
  endtask

  task automatic test_directed();
    logic [63:0] big_sq;
    big_sq = odd_square(32'hFFFF_FFFB);
    send_candidate(64'd0, 10'd0);
    send_candidate(64'd1, 10'd0);
    send_candidate(64'd1, 10'd2);
    send_candidate(64'd9, 10'd1);
    send_candidate(64'd9, 10'd3);
    send_candidate(64'd17, 10'd4);
    send_candidate(64'd17, 10'd16);
    send_candidate(64'd17, 10'd17);
    send_candidate(64'd1, 10'd1023);
    send_candidate({64{1'b1}}, 10'd1023);
    send_candidate(64'hFFFF_FFFF_FFFF_FFF9, 10'd1023);
    send_candidate(64'h8000_0000_0000_0001, 10'd512);
    send_candidate(64'd143641, 10'd1023);
    send_candidate(64'd143641, 10'd372);
    // 373 squared: every symbol is 1 except the last prime, which divides n
    send_candidate(64'd139129, 10'd372);
    send_candidate(64'd139129, 10'd373);
    send_candidate(64'd139129, 10'd374);
    send_candidate(big_sq, 10'd1023);
    send_candidate(big_sq, 10'd5);
    send_candidate(64'd225, 10'd4);
    send_candidate(64'd225, 10'd5);
    send_candidate(64'h5555_5555_5555_5551, 10'd341);
    send_candidate(64'hAAAA_AAAA_AAAA_AAA9, 10'd682);
  endtask

  // receiver holds off while cheap candidates keep coming, so the core fills
  task automatic test_output_stall();
    hold_off_req = 1'b1;
    burst_left   = 12;
    for (int i = 0; i < 12; i++)
      send_candidate({$urandom, $urandom} & ~64'd1, 10'($urandom_range(0, 1023)));
    while (hold_off_req) @(posedge clk);
  endtask

  task automatic test_random(input int count);
    logic [63:0] n;
    logic [9:0]  lim;
    int          pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        // noise: any value, mostly rejected by the mod 8 test
        n   = {$urandom, $urandom};
        lim = 10'($urandom_range(0, 1023));
      end else if (pick < 50) begin
        n      = {$urandom, $urandom};
        n[2:0] = 3'b001;
        lim    = 10'($urandom_range(0, 1023));
      end else if (pick < 95) begin
        n   = odd_square($urandom);
        lim = 10'($urandom_range(0, 80));
      end else begin
        n   = odd_square($urandom);
        lim = 10'($urandom_range(FULL_LIMIT, 1023));
      end
      send_candidate(n, lim);
      if (i == count / 2) drain_results();
    end
  endtask

  // receiver: long hold-off on request, otherwise changing stall patterns
  initial begin
    ready_mode_t mode;
    int          mode_left;
    int          hold_left;
    int          tick;
    out_ready <= 1'b0;
    mode_left = 0;
    hold_left = 0;
    tick      = 0;
    mode      = READY_ALWAYS;
    forever begin
      @(posedge clk);
      tick++;
      if (hold_left > 0) begin
        out_ready <= 1'b0;
        hold_left--;
        if (hold_left == 0) hold_off_req = 1'b0;
      end else if (hold_off_req) begin
        out_ready <= 1'b0;
        hold_left = HOLD_CYCLES;
      end else begin
        if (mode_left == 0) begin
          mode      = ready_mode_t'($urandom_range(0, 2));
          mode_left = $urandom_range(10, 200);
        end
        mode_left--;
        case (mode)
          READY_ALWAYS:   out_ready <= 1'b1;
          READY_RANDOM:   out_ready <= 1'($urandom_range(0, 1));
          default:        out_ready <= (tick % 4 != 0);
        endcase
      end
    end
  end

  // result checker
  always @(posedge clk) begin
    bit exp_bit;
    if (rst_n && out_valid && out_ready) begin
      if (expected_pseudo.size() == 0) begin
        $error("unexpected result transaction: is_pseudo %0b", out_is_pseudo);
        fail_count++;
      end else begin
        exp_bit = expected_pseudo.pop_front();
        if (exp_bit) passing_seen++;
        if (out_is_pseudo !== exp_bit) begin
          $error("is_pseudo mismatch: expected %0b, actual %0b", exp_bit, out_is_pseudo);
          fail_count++;
        end
      end
    end
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no transaction for %0d cycles", IDLE_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // main sequence
  initial begin
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_n_value     <= '0;
    in_prime_limit <= '0;
    fail_count     = 0;
    burst_left     = 0;
    hold_off_req   = 1'b0;
    fill_odd_primes();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed();
    drain_results();
    test_output_stall();
    drain_results();
    test_random(RANDOM_ITEMS);
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d candidates (%0d against the whole prime table), %0d passing",
             candidates_sent, full_table_items, passing_seen);
    $display("with sender gaps, receiver stalls and one long output hold-off");
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
src/pjc_pkg.sv
src/pjc_mod_unit.sv
src/pseudosquare_jacobi_check_core.sv
bench/testbench.sv
